// ===== rtl/core/rgb_box_downsample_2x2_assert.svh =====
// Assertion helpers shared by the RTL; all sample on clk_i and are disabled in reset.
`ifndef RGB_BOX_DOWNSAMPLE_2X2_ASSERT_SVH
`define RGB_BOX_DOWNSAMPLE_2X2_ASSERT_SVH

// Same-cycle implication.
`define RBD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_box_downsample_2x2: assertion failed");

// Next-cycle implication.
`define RBD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_box_downsample_2x2: assertion failed");

`endif

// ===== rtl/core/rbd_pkg.sv =====
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int CHAN_W          = 8;
  localparam int PIX_W           = 3 * CHAN_W;
  localparam int PAIR_CHAN_W     = CHAN_W + 1;
  localparam int PAIR_W          = 3 * PAIR_CHAN_W;

  localparam int SRC_WIDTH_W     = 12;
  localparam int SRC_HEIGHT_W    = 13;
  localparam int ROW_W           = 12;
  localparam int CFG_DATA_W      = 13;
  localparam int CFG_IDX_W       = 1;

  localparam int DEF_MAX_SOURCE_WIDTH = 2048;
  localparam int MAX_SOURCE_HEIGHT    = 4096;
  localparam int SRC_WIDTH_RESET      = 256;
  localparam int SRC_HEIGHT_RESET     = 256;

  localparam int QUEUE_DEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  // One queued job for the back end. The line-store slot travels beside it.
  typedef struct packed {
    logic                is_read;   // odd row: read above, emit result
    logic [PAIR_W-1:0]   pair;      // 9 bits per channel, red in the low bits
    logic                row_end;
    logic                image_end;
  } rbd_op_t;

endpackage

// ===== rtl/core/rbd_ram.sv =====
`timescale 1ns / 1ps

module rbd_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/rbd_front.sv =====
`timescale 1ns / 1ps

module rbd_front
  import rbd_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  localparam int LINE_DEPTH = MAX_SOURCE_WIDTH / 2,
  localparam int SW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CHAN_W-1:0]     red_in_i,
  input  logic [CHAN_W-1:0]     green_in_i,
  input  logic [CHAN_W-1:0]     blue_in_i,
  output logic                  push_o,
  output rbd_op_t               op_o,
  output logic [SW-1:0]         slot_o
);

  localparam int CW = (MAX_SOURCE_WIDTH > 2) ? $clog2(MAX_SOURCE_WIDTH) : 1;
  localparam int EW = $clog2(MAX_SOURCE_WIDTH + 1);
  localparam int WW = (EW > SRC_WIDTH_W) ? EW : SRC_WIDTH_W;
  localparam int HW = SRC_HEIGHT_W;

  logic [SRC_WIDTH_W-1:0]  width_q;
  logic [SRC_HEIGHT_W-1:0] height_q;
  logic [CW-1:0]           col_q, col_d;
  logic [ROW_W-1:0]        row_q, row_d;
  logic [PIX_W-1:0]        left_q;

  logic [PIX_W-1:0] pix;
  logic [WW-1:0]    w_ext, w_eff, w_lim, col_ext, col_inc;
  logic [HW-1:0]    h_eff, h_lim, row_ext, row_inc;
  logic             accept, in_range;

  assign pix    = {blue_in_i, green_in_i, red_in_i};
  assign accept = in_valid_i && !in_stall_i;

  // effective sizes, clamped; only even extents produce output
  always_comb begin
    w_ext = WW'(width_q);
    if (w_ext < WW'(2)) begin
      w_eff = WW'(2);
    end else if (w_ext > WW'(MAX_SOURCE_WIDTH)) begin
      w_eff = WW'(MAX_SOURCE_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (height_q < HW'(2)) begin
      h_eff = HW'(2);
    end else if (height_q > HW'(MAX_SOURCE_HEIGHT)) begin
      h_eff = HW'(MAX_SOURCE_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign w_lim    = {w_eff[WW-1:1], 1'b0};
  assign h_lim    = {h_eff[HW-1:1], 1'b0};
  assign col_ext  = WW'(col_q);
  assign row_ext  = HW'(row_q);
  assign in_range = (col_ext < w_lim) && (row_ext < h_lim);
  assign col_inc  = col_ext + WW'(1);
  assign row_inc  = row_ext + HW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SRC_WIDTH_W'(SRC_WIDTH_RESET);
      height_q <= SRC_HEIGHT_W'(SRC_HEIGHT_RESET);
      col_q    <= '0;
      row_q    <= '0;
      left_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_IDX_WIDTH:  width_q  <= cfg_data_i[SRC_WIDTH_W-1:0];
          CFG_IDX_HEIGHT: height_q <= cfg_data_i[SRC_HEIGHT_W-1:0];
          default: ;
        endcase
        // any write restarts the image
        col_q <= '0;
        row_q <= '0;
      end else begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (accept && in_range && !col_q[0]) begin
        left_q <= pix;
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      op_o.pair[c*PAIR_CHAN_W +: PAIR_CHAN_W] =
        {1'b0, left_q[c*CHAN_W +: CHAN_W]} + {1'b0, pix[c*CHAN_W +: CHAN_W]};
    end
    op_o.is_read   = row_q[0];
    op_o.row_end   = (col_ext == w_lim - WW'(1));
    op_o.image_end = op_o.row_end && (row_ext == h_lim - HW'(1));
  end

  assign slot_o = SW'(col_q >> 1);
  assign push_o = accept && in_range && col_q[0];

`include "rgb_box_downsample_2x2_assert.svh"

  `RBD_ASSERT_IMP(a_push_odd_col, push_o, col_q[0] && (col_ext < w_lim))

endmodule

// ===== rtl/core/rbd_fifo.sv =====
`timescale 1ns / 1ps

module rbd_fifo #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 4,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [NW-1:0]    count_q;

  assign full_o  = (count_q == NW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign rdata_o = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + NW'(1);
        2'b01:   count_q <= count_q - NW'(1);
        default: ;
      endcase
    end
  end

`include "rgb_box_downsample_2x2_assert.svh"

  `RBD_ASSERT_IMP(a_no_overflow, push_i, !full_o)

endmodule

// ===== rtl/core/rbd_back.sv =====
`timescale 1ns / 1ps

module rbd_back
  import rbd_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH,
  localparam int LINE_DEPTH = MAX_SOURCE_WIDTH / 2,
  localparam int SW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  rbd_op_t           job_i,
  input  logic [SW-1:0]     slot_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAN_W-1:0] red_out_o,
  output logic [CHAN_W-1:0] green_out_o,
  output logic [CHAN_W-1:0] blue_out_o,
  output logic              row_end_o,
  output logic              image_end_o
);

  logic              s1_vld_q;
  logic [PAIR_W-1:0] s1_pair_q;
  logic              s1_rend_q, s1_iend_q;
  logic              out_vld_q;
  logic [PIX_W-1:0]  out_pix_q;
  logic              out_rend_q, out_iend_q;

  logic              out_ready, s1_go, s1_free, ram_we, ram_re;
  logic [PAIR_W-1:0] above;
  logic [PIX_W-1:0]  avg;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign s1_go     = s1_vld_q && out_ready;
  assign s1_free   = !s1_vld_q || out_ready;
  // line-store writes need no downstream room
  assign pop_o     = job_valid_i && (!job_i.is_read || s1_free);
  assign ram_we    = pop_o && !job_i.is_read;
  assign ram_re    = pop_o && job_i.is_read;

  rbd_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_i),
    .wdata_i (job_i.pair),
    .re_i    (ram_re),
    .raddr_i (slot_i),
    .rdata_o (above)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      avg[c*CHAN_W +: CHAN_W] =
        CHAN_W'(10'({1'b0, above[c*PAIR_CHAN_W +: PAIR_CHAN_W]}
          + {1'b0, s1_pair_q[c*PAIR_CHAN_W +: PAIR_CHAN_W]}) >> 2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (ram_re) begin
        s1_vld_q <= 1'b1;
      end else if (s1_go) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_go) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      s1_pair_q <= job_i.pair;
      s1_rend_q <= job_i.row_end;
      s1_iend_q <= job_i.image_end;
    end
    if (s1_go) begin
      out_pix_q  <= avg;
      out_rend_q <= s1_rend_q;
      out_iend_q <= s1_iend_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign red_out_o   = out_pix_q[0*CHAN_W +: CHAN_W];
  assign green_out_o = out_pix_q[1*CHAN_W +: CHAN_W];
  assign blue_out_o  = out_pix_q[2*CHAN_W +: CHAN_W];
  assign row_end_o   = out_rend_q;
  assign image_end_o = out_iend_q;

`include "rgb_box_downsample_2x2_assert.svh"

  `RBD_ASSERT_NXT(a_s1_held, s1_vld_q && !out_ready, s1_vld_q && $stable(s1_pair_q))
  `RBD_ASSERT_IMP(a_read_has_room, ram_re, s1_free)
  `RBD_ASSERT_IMP(a_iend_on_rend, out_vld_q && out_iend_q, out_rend_q)

endmodule

// ===== rtl/core/rgb_box_downsample_2x2.sv =====
`timescale 1ns / 1ps
// 2x2 box-filter downsampler: one mipmap level of an 8-bit RGB image.
// Input: source pixels in raster order, one per beat (in_valid_i / in_stall_o).
// Output: one averaged pixel per 2x2 block (out_valid_o / out_stall_i), with
//   row_end_o on the last pixel of an output row and image_end_o on the last
//   of the image. Trailing odd columns and rows are consumed silently.
// Config: cfg_we_i writes source width (index 0) or height (index 1); any
//   write restarts the image at row 0, column 0. Write only while idle.
// Throughput: one pixel per cycle unless stalled. Even source rows store
//   horizontal pair sums in a line RAM; odd rows read them back, so the RAM's
//   single read and write ports carry at most one job per cycle.
// Path: a block's result passes through the job queue, the RAM read and the
//   output register, and is held up further while the queue is backed up.
// Stall: the output register holds while out_stall_i is high; a 4-entry job
//   queue keeps taking input until full, then in_stall_o rises.
// Reset: counters clear, width and height return to 256. The line RAM is not
//   cleared; every entry is written on an even row before it is read.
module rgb_box_downsample_2x2
  import rbd_pkg::*;
#(
  parameter int MAX_SOURCE_WIDTH = DEF_MAX_SOURCE_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CHAN_W-1:0]     red_in_i,
  input  logic [CHAN_W-1:0]     green_in_i,
  input  logic [CHAN_W-1:0]     blue_in_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAN_W-1:0]     red_out_o,
  output logic [CHAN_W-1:0]     green_out_o,
  output logic [CHAN_W-1:0]     blue_out_o,
  output logic                  row_end_o,
  output logic                  image_end_o
);

  localparam int LINE_DEPTH = MAX_SOURCE_WIDTH / 2;
  localparam int SW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int QW = SW + $bits(rbd_op_t);

  logic          push, full, job_valid, pop;
  rbd_op_t       fe_op, job;
  logic [SW-1:0] fe_slot, job_slot;
  logic [QW-1:0] q_wdata, q_rdata;

  assign in_stall_o = full;

  rbd_front #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (full),
    .red_in_i    (red_in_i),
    .green_in_i  (green_in_i),
    .blue_in_i   (blue_in_i),
    .push_o      (push),
    .op_o        (fe_op),
    .slot_o      (fe_slot)
  );

  assign q_wdata  = {fe_slot, fe_op};
  assign job_slot = q_rdata[QW-1 -: SW];
  assign job      = q_rdata[$bits(rbd_op_t)-1:0];

  rbd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (q_wdata),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .rdata_o (q_rdata)
  );

  rbd_back #(
    .MAX_SOURCE_WIDTH (MAX_SOURCE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .slot_i      (job_slot),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o)
  );

endmodule
